>>> rtl/core/mbse_pkg.sv
// ----------------------------------------------------------------------------
// mbse_pkg: shared types and constants for the request executor
// Command codes, function codes, exception codes, item types and the CRC step.
// ----------------------------------------------------------------------------
package mbse_pkg;

  localparam logic [1:0] CMD_FRAME = 2'd0;
  localparam logic [1:0] CMD_TABLE = 2'd1;
  localparam logic [1:0] CMD_PULL  = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  localparam logic [7:0] FN_READ_COILS  = 8'h01;
  localparam logic [7:0] FN_READ_INPUTS = 8'h02;
  localparam logic [7:0] FN_READ_HOLD   = 8'h03;
  localparam logic [7:0] FN_READ_INREG  = 8'h04;
  localparam logic [7:0] FN_WRITE_ONE   = 8'h06;
  localparam logic [7:0] FN_WRITE_MANY  = 8'h10;

  localparam logic [7:0] EXC_FUNC  = 8'h01;
  localparam logic [7:0] EXC_ADDR  = 8'h02;
  localparam logic [7:0] EXC_VALUE = 8'h03;
  localparam logic [7:0] EXC_FLAG  = 8'h80;

  localparam int unsigned MAX_BITS = 2000;
  localparam int unsigned MAX_WRITE = 500;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_byte;
    logic       frame_end;
    logic [4:0] table_index;
  } req_t;

  typedef struct packed {
    logic [7:0] resp_byte;
    logic       resp_last;
    logic       resp_empty;
  } rsp_t;

  // One Modbus CRC-16 byte update (reflected poly 0xA001).
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> rtl/core/mbse_stream_if.sv
// ----------------------------------------------------------------------------
// mbse_stream_if: valid/ready channel
// Generic handshake channel carrying a payload of type T.
// ----------------------------------------------------------------------------
interface mbse_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/mbse_ram.sv
// ----------------------------------------------------------------------------
// mbse_ram: single-port synchronous RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module mbse_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

>>> rtl/core/modbus_slave_request_executor_unit.sv
// ----------------------------------------------------------------------------
// modbus_slave_request_executor_unit: Modbus slave request executor
// Frame buffer, holding registers and bit table in single-port RAMs, walked
// by one sequencer that executes the request and appends the CRC.
// ----------------------------------------------------------------------------
// A new frame byte, bit-table load or pull is accepted only once the previous
// one is done; a pull waits in place while the previous response byte is still
// held in the output register. The final byte of a frame of eight bytes or more
// starts execution, which walks the frame buffer RAM: the header is read up to
// dispatch, then registers are read or written, or the response bytes are
// cleared and the bits read, or an exception is written, and a CRC pass over
// the response is followed by appending the CRC. Every store is a one-port RAM;
// after reset the holding register and bit table RAMs are cleared before any
// item is accepted.
module modbus_slave_request_executor_unit #(
  parameter int unsigned BufBytes    = 256,
  parameter int unsigned HoldRegs    = 64,
  parameter int unsigned BitBytes    = 32,
  parameter int unsigned MaxReadRegs = 125
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  mbse_stream_if.sink   in_if,
  mbse_stream_if.source out_if
);
  localparam int unsigned BA = (BufBytes > 1) ? $clog2(BufBytes) : 1;
  localparam int unsigned HA = (HoldRegs > 1) ? $clog2(HoldRegs) : 1;
  localparam int unsigned TA = (BitBytes > 1) ? $clog2(BitBytes) : 1;
  localparam int unsigned ClrN = (HoldRegs > BitBytes) ? HoldRegs : BitBytes;

  localparam logic [4:0] S_CLR   = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_TBLW  = 5'd2;
  localparam logic [4:0] S_PULL  = 5'd3;
  localparam logic [4:0] S_OUT   = 5'd4;
  localparam logic [4:0] S_HDR   = 5'd5;
  localparam logic [4:0] S_HDRW  = 5'd6;
  localparam logic [4:0] S_DISP  = 5'd7;
  localparam logic [4:0] S_EXC1  = 5'd8;
  localparam logic [4:0] S_EXC2  = 5'd9;
  localparam logic [4:0] S_RRH   = 5'd10;
  localparam logic [4:0] S_RRW   = 5'd11;
  localparam logic [4:0] S_RBZ   = 5'd12;
  localparam logic [4:0] S_RBT   = 5'd13;
  localparam logic [4:0] S_RBM   = 5'd14;
  localparam logic [4:0] S_RBW   = 5'd15;
  localparam logic [4:0] S_WMR   = 5'd16;
  localparam logic [4:0] S_WMW   = 5'd17;
  localparam logic [4:0] S_CRCR  = 5'd18;
  localparam logic [4:0] S_CRCA  = 5'd19;
  localparam logic [4:0] S_CRCW  = 5'd20;
  localparam logic [4:0] S_FRAME = 5'd21;
  localparam logic [4:0] S_WMX   = 5'd22;

  logic [4:0]  st_q, st_d;
  logic [8:0]  rx_q, rx_d, len_q, len_d, pos_q, pos_d;
  logic [16:0] w1_q, w1_d, w2_q, w2_d; // w1 start, w2 count
  logic [7:0]  fn_q, fn_d, tmp_q, tmp_d;
  logic [16:0] i_q, i_d;
  logic [1:0]  ph_q, ph_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] cnt_q, cnt_d;
  logic [7:0]  dat_q, dat_d;
  logic        fe_q, fe_d;
  logic [4:0]  ti_q, ti_d;
  logic [7:0]  ob_q, ob_d;
  logic        ol_q, ol_d, oe_q, oe_d, ov_q, ov_d;

  logic          fb_we, hr_we, bt_we;
  logic [BA-1:0] fb_a;
  logic [HA-1:0] hr_a;
  logic [TA-1:0] bt_a;
  logic [7:0]    fb_wd, fb_rd, bt_wd, bt_rd;
  logic [15:0]   hr_wd, hr_rd;

  mbse_ram #(.Width(8), .Depth(BufBytes)) u_fb (
    .clk_i, .we_i(fb_we), .addr_i(fb_a), .wdata_i(fb_wd), .rdata_o(fb_rd));
  mbse_ram #(.Width(16), .Depth(HoldRegs)) u_hr (
    .clk_i, .we_i(hr_we), .addr_i(hr_a), .wdata_i(hr_wd), .rdata_o(hr_rd));
  mbse_ram #(.Width(8), .Depth(BitBytes)) u_bt (
    .clk_i, .we_i(bt_we), .addr_i(bt_a), .wdata_i(bt_wd), .rdata_o(bt_rd));

  assign in_if.ready = (st_q == S_IDLE);
  assign out_if.valid = ov_q;
  assign out_if.data.resp_byte = ob_q;
  assign out_if.data.resp_last = ol_q;
  assign out_if.data.resp_empty = oe_q;

  logic [17:0] bit_a;
  logic [16:0] nbytes;
  assign bit_a = {1'b0, w1_q} + {1'b0, i_q};
  assign nbytes = (w2_q + 17'd7) >> 3;

  always_comb begin
    st_d = st_q; rx_d = rx_q; len_d = len_q; pos_d = pos_q;
    w1_d = w1_q; w2_d = w2_q; fn_d = fn_q; tmp_d = tmp_q; i_d = i_q;
    ph_d = ph_q; crc_d = crc_q; cnt_d = cnt_q;
    dat_d = dat_q; fe_d = fe_q; ti_d = ti_q;
    ob_d = ob_q; ol_d = ol_q; oe_d = oe_q; ov_d = ov_q;
    fb_we = 1'b0; fb_a = '0; fb_wd = '0;
    hr_we = 1'b0; hr_a = '0; hr_wd = '0;
    bt_we = 1'b0; bt_a = '0; bt_wd = '0;
    if (ov_q && out_if.ready) ov_d = 1'b0;
    case (st_q)
      S_CLR: begin
        hr_we = (cnt_q < 16'(HoldRegs)); hr_a = HA'(cnt_q);
        bt_we = (cnt_q < 16'(BitBytes)); bt_a = TA'(cnt_q);
        cnt_d = cnt_q + 16'd1;
        if (cnt_q == 16'(ClrN - 1)) st_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_if.valid) begin
          dat_d = in_if.data.data_byte;
          fe_d = in_if.data.frame_end; ti_d = in_if.data.table_index;
          case (in_if.data.cmd)
            mbse_pkg::CMD_FRAME: st_d = S_FRAME;
            mbse_pkg::CMD_TABLE: st_d = S_TBLW;
            mbse_pkg::CMD_PULL: begin
              st_d = S_PULL;
              fb_a = BA'(pos_q);
            end
            default: st_d = S_IDLE;
          endcase
        end
      end
      S_TBLW: begin
        bt_we = ({27'd0, ti_q} < 32'(BitBytes)); bt_a = TA'(ti_q); bt_wd = dat_q;
        st_d = S_IDLE;
      end
      // hold the read address so the byte stays put while the output is full
      S_PULL: begin
        fb_a = BA'(pos_q);
        if (!ov_q || out_if.ready) begin
          ov_d = 1'b1;
          if (pos_q < len_q && pos_q < 9'(BufBytes)) begin
            ob_d = fb_rd; ol_d = (pos_q + 9'd1 == len_q); oe_d = 1'b0;
            pos_d = pos_q + 9'd1;
          end else begin
            ob_d = 8'd0; ol_d = 1'b0; oe_d = 1'b1;
          end
          st_d = S_IDLE;
        end
      end
      S_FRAME: begin
        len_d = '0; pos_d = '0;
        if (rx_q < 9'(BufBytes)) begin
          fb_we = 1'b1; fb_a = BA'(rx_q); fb_wd = dat_q;
          rx_d = rx_q + 9'd1;
        end
        st_d = S_IDLE;
        if (fe_q) begin
          if (((rx_q < 9'(BufBytes)) ? rx_q + 9'd1 : rx_q) < 9'd8) rx_d = '0;
          else begin
            st_d = S_HDR; i_d = 17'd1;
            if (rx_q < 9'(BufBytes)) rx_d = rx_q + 9'd1;
          end
        end
      end
      // read bytes 1..5 into fn, w1, w2
      S_HDR: begin
        fb_a = BA'(i_q); st_d = S_HDRW;
      end
      S_HDRW: begin
        case (i_q[2:0])
          3'd1: fn_d = fb_rd;
          3'd2: w1_d = {1'b0, fb_rd, 8'd0};
          3'd3: w1_d = {w1_q[16:8], fb_rd};
          3'd4: w2_d = {1'b0, fb_rd, 8'd0};
          default: w2_d = {w2_q[16:8], fb_rd};
        endcase
        i_d = i_q + 17'd1;
        st_d = (i_q == 17'd5) ? S_DISP : S_HDR;
      end
      S_DISP: begin
        i_d = '0; crc_d = 16'hFFFF;
        st_d = S_EXC1;
        case (fn_q)
          mbse_pkg::FN_READ_HOLD, mbse_pkg::FN_READ_INREG: begin
            if (w2_q < 17'd1 || w2_q > 17'(MaxReadRegs) ||
                {w2_q, 1'b0} + 18'd5 > 18'(BufBytes)) tmp_d = mbse_pkg::EXC_VALUE;
            else if (w1_q + w2_q > 17'(HoldRegs)) tmp_d = mbse_pkg::EXC_ADDR;
            else begin
              fb_we = 1'b1; fb_a = BA'(2); fb_wd = {w2_q[6:0], 1'b0};
              len_d = 9'(3 + {w2_q[7:0], 1'b0}); st_d = S_RRH;
            end
          end
          mbse_pkg::FN_READ_COILS, mbse_pkg::FN_READ_INPUTS: begin
            if (w2_q < 17'd1 || w2_q > 17'(mbse_pkg::MAX_BITS) ||
                nbytes + 17'd5 > 17'(BufBytes)) tmp_d = mbse_pkg::EXC_VALUE;
            else if ({1'b0, w1_q} + {1'b0, w2_q} > 18'(8 * BitBytes))
              tmp_d = mbse_pkg::EXC_ADDR;
            else begin
              fb_we = 1'b1; fb_a = BA'(2); fb_wd = nbytes[7:0];
              len_d = 9'(17'd3 + nbytes); st_d = S_RBZ;
            end
          end
          mbse_pkg::FN_WRITE_ONE: begin
            if (w1_q >= 17'(HoldRegs)) tmp_d = mbse_pkg::EXC_ADDR;
            else begin
              hr_we = 1'b1; hr_a = HA'(w1_q); hr_wd = w2_q[15:0];
              len_d = 9'd6; st_d = S_CRCR;
            end
          end
          mbse_pkg::FN_WRITE_MANY: begin
            if (w2_q < 17'd1 || w2_q > 17'(mbse_pkg::MAX_WRITE) ||
                {w2_q, 1'b0} + 18'd9 > {9'd0, rx_q}) tmp_d = mbse_pkg::EXC_VALUE;
            else if (w1_q + w2_q > 17'(HoldRegs)) tmp_d = mbse_pkg::EXC_ADDR;
            else begin
              len_d = 9'd6; st_d = S_WMR; ph_d = '0;
            end
          end
          default: tmp_d = mbse_pkg::EXC_FUNC;
        endcase
      end
      S_EXC1: begin
        fb_we = 1'b1; fb_a = BA'(1); fb_wd = fn_q | mbse_pkg::EXC_FLAG;
        st_d = S_EXC2;
      end
      S_EXC2: begin
        fb_we = 1'b1; fb_a = BA'(2); fb_wd = tmp_q;
        len_d = 9'd3; i_d = '0; st_d = S_CRCR;
      end
      S_RRH: begin
        hr_a = HA'(w1_q + i_q); st_d = S_RRW; ph_d = '0;
      end
      S_RRW: begin
        fb_we = 1'b1;
        if (ph_q == 2'd0) begin
          fb_a = BA'(18'd3 + {i_q, 1'b0}); fb_wd = hr_rd[15:8];
          tmp_d = hr_rd[7:0]; ph_d = 2'd1;
        end else begin
          fb_a = BA'(18'd4 + {i_q, 1'b0}); fb_wd = tmp_q;
          i_d = i_q + 17'd1;
          st_d = (i_q + 17'd1 == w2_q) ? S_CRCR : S_RRH;
          if (i_q + 17'd1 == w2_q) i_d = '0;
        end
      end
      S_RBZ: begin
        fb_we = 1'b1; fb_a = BA'(17'd3 + i_q); fb_wd = 8'd0;
        i_d = i_q + 17'd1;
        if (i_q + 17'd1 == nbytes) begin i_d = '0; st_d = S_RBT; end
      end
      // i walks bits; tmp accumulates the output byte
      S_RBT: begin
        bt_a = TA'(bit_a >> 3); st_d = S_RBM;
        if (i_q[2:0] == 3'd0) tmp_d = '0;
      end
      S_RBM: begin
        tmp_d = tmp_q | ({7'd0, bt_rd[bit_a[2:0]]} << i_q[2:0]);
        st_d = S_RBW;
      end
      S_RBW: begin
        i_d = i_q + 17'd1;
        st_d = S_RBT;
        if (i_q[2:0] == 3'd7 || i_q + 17'd1 == w2_q) begin
          fb_we = 1'b1; fb_a = BA'(17'd3 + (i_q >> 3)); fb_wd = tmp_q;
        end
        if (i_q + 17'd1 == w2_q) begin i_d = '0; st_d = S_CRCR; end
      end
      S_WMR: begin
        fb_a = BA'(18'd7 + {i_q, ph_q[0]}); st_d = S_WMW;
      end
      S_WMW: begin
        if (ph_q == 2'd0) begin
          tmp_d = fb_rd; ph_d = 2'd1; st_d = S_WMR;
        end else begin
          hr_we = 1'b1; hr_a = HA'(w1_q + i_q); hr_wd = {tmp_q, fb_rd};
          ph_d = 2'd0; i_d = i_q + 17'd1; st_d = S_WMR;
          if (i_q + 17'd1 == w2_q) begin i_d = '0; st_d = S_CRCR; end
        end
      end
      S_WMX: st_d = S_CRCR;
      S_CRCR: begin
        if (i_q == {8'd0, len_q}) begin
          fb_we = 1'b1; fb_a = BA'(len_q); fb_wd = crc_q[7:0]; st_d = S_CRCW;
        end else begin
          fb_a = BA'(i_q); st_d = S_CRCA;
        end
      end
      S_CRCA: begin
        crc_d = mbse_pkg::crc_byte(crc_q, fb_rd);
        i_d = i_q + 17'd1; st_d = S_CRCR;
      end
      S_CRCW: begin
        fb_we = 1'b1; fb_a = BA'(len_q + 9'd1); fb_wd = crc_q[15:8];
        len_d = len_q + 9'd2; pos_d = '0; rx_d = '0; st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLR; rx_q <= '0; len_q <= '0; pos_q <= '0; cnt_q <= '0;
      ov_q <= 1'b0; i_q <= '0; ph_q <= '0;
    end else begin
      st_q <= st_d; rx_q <= rx_d; len_q <= len_d; pos_q <= pos_d; cnt_q <= cnt_d;
      ov_q <= ov_d; i_q <= i_d; ph_q <= ph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w1_q <= w1_d; w2_q <= w2_d; fn_q <= fn_d; tmp_q <= tmp_d; crc_q <= crc_d;
    dat_q <= dat_d; fe_q <= fe_d; ti_q <= ti_d;
    ob_q <= ob_d; ol_q <= ol_d; oe_q <= oe_d;
  end

  a_pos_le_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_IDLE) |-> (pos_q <= len_q)) else $error("pos beyond len");
  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_PULL) |=> ov_q) else $error("pull gave no result");
  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && oe_q) |-> (ob_q == 8'd0 && !ol_q)) else $error("empty result not zero");
endmodule
